// ----- sv/i2cm_pkg.sv -----
`default_nettype none
package i2cm_pkg;
  localparam int unsigned RecoveryPulses = 9;
  localparam int unsigned PulseW = $clog2(RecoveryPulses + 1);
  localparam logic [15:0] StretchReset = 16'd101;
  localparam int unsigned QDepth = 2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2,
    PH_TX0, PH_TXW, PH_TX2, PH_AK0, PH_AKW, PH_AK2,
    PH_RX0, PH_RXW, PH_RX2, PH_MA0, PH_MA1, PH_MA2,
    PH_SP0, PH_SP1, PH_SP2,
    PH_RC0, PH_RC1, PH_RC2, PH_RC3, PH_RC4
  } phase_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0, OP_READ = 2'd1, OP_RECOVER = 2'd2, OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_STUCK = 2'd2;

  // classified input word
  typedef struct packed {
    logic       is_tick;
    op_t        op;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_len;
    logic       scl;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       scl_oe;
    logic       scl_out;
    logic       sda_oe;
    logic       sda_out;
    logic       busy;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       rd_last;
    logic       done;
    logic [1:0] status;
  } res_t;
endpackage
`default_nettype wire

// ----- sv/i2c_master_register_access.sv -----
// a word's result is registered in the queue and then in the result register before it reaches the result side
// one word per cycle while the result side keeps popping; a two-word queue sits between intake and bus engine
// the bus engine steps one bus phase per tick word; the result register frees on pop
// reset (rst_n low, synchronous): idle, both lines released, budget 101, queues empty
`default_nettype none
module i2c_master_register_access import i2cm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_kind,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_dev_addr,
  input  wire logic [7:0]  in_reg_addr,
  input  wire logic [7:0]  in_wr_data,
  input  wire logic [7:0]  in_rd_len,
  input  wire logic        in_scl_in,
  input  wire logic        in_sda_in,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_scl_oe,
  output logic             out_scl_out,
  output logic             out_sda_oe,
  output logic             out_sda_out,
  output logic             out_busy_res,
  output logic             out_rd_valid,
  output logic [7:0]       out_rd_byte,
  output logic             out_rd_last,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_stretch_budget
);
  logic  q_valid, q_take, res_valid;
  item_t q_item;
  res_t  res;

  i2cm_front u_front (
    .clk, .rst_n, .push, .full, .in_kind, .in_op, .in_dev_addr, .in_reg_addr,
    .in_wr_data, .in_rd_len, .in_scl_in, .in_sda_in, .q_valid, .q_item, .q_take
  );

  i2cm_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_stretch_budget), .q_valid, .q_item,
    .q_take, .res, .res_valid, .res_take(pop)
  );

  assign empty        = !res_valid;
  assign out_scl_oe   = res.scl_oe;
  assign out_scl_out  = res.scl_out;
  assign out_sda_oe   = res.sda_oe;
  assign out_sda_out  = res.sda_out;
  assign out_busy_res = res.busy;
  assign out_rd_valid = res.rd_valid;
  assign out_rd_byte  = res.rd_byte;
  assign out_rd_last  = res.rd_last;
  assign out_done_res = res.done;
  assign out_status   = res.status;
endmodule
`default_nettype wire

// ----- sv/i2cm_front.sv -----
`default_nettype none
module i2cm_front import i2cm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic       in_kind,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_dev_addr,
  input  wire logic [7:0] in_reg_addr,
  input  wire logic [7:0] in_wr_data,
  input  wire logic [7:0] in_rd_len,
  input  wire logic       in_scl_in,
  input  wire logic       in_sda_in,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_take
);
  // two-entry queue towards the bus engine
  item_t mem_r [QDepth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;
  item_t      cls;

  always_comb begin
    cls.is_tick  = in_kind;
    cls.op       = op_t'(in_op);
    cls.dev_addr = in_dev_addr;
    cls.reg_addr = in_reg_addr;
    cls.wr_data  = in_wr_data;
    cls.rd_len   = in_rd_len;
    cls.scl      = in_scl_in;
    cls.sda      = in_sda_in;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (wr) mem_r[wp_r] <= cls;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> (wp_r == rp_r))
    else $error("empty queue pointers differ");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd2) |-> (wp_r == rp_r))
    else $error("full queue pointers differ");
endmodule
`default_nettype wire

// ----- sv/i2cm_back.sv -----
`default_nettype none
module i2cm_back import i2cm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_take,
  output res_t             res,
  output logic             res_valid,
  input  wire logic        res_take
);
  phase_t      ph_r, ph_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [7:0]  sh_r, sh_nxt, left_r, left_nxt;
  logic [15:0] str_r, str_nxt, budget_r;
  op_t         op_r, op_nxt;
  logic [7:0]  dev_r, dev_nxt, reg_r, reg_nxt, dat_r, dat_nxt;
  logic [PulseW-1:0] pc_r, pc_nxt;
  logic        scloe_r, scloe_nxt, scllv_r, scllv_nxt;
  logic        sdaoe_r, sdaoe_nxt, sdalv_r, sdalv_nxt;
  logic        nack_r, nack_nxt;
  res_t        res_nxt, res_r;
  logic        rv_r, go, bit_inc;
  logic [3:0]  bit_p1;

  // output register: take next word when no result is held or the held result is consumed
  assign go        = q_valid && (!rv_r || res_take);
  assign q_take    = go;
  assign res       = res_r;
  assign res_valid = rv_r;
  assign bit_p1    = bit_r + 4'd1;

  always_comb begin
    ph_nxt = ph_r; bit_nxt = bit_r; step_nxt = step_r; sh_nxt = sh_r;
    left_nxt = left_r; str_nxt = str_r; op_nxt = op_r; dev_nxt = dev_r;
    reg_nxt = reg_r; dat_nxt = dat_r; pc_nxt = pc_r; nack_nxt = nack_r;
    scloe_nxt = scloe_r; scllv_nxt = scllv_r;
    sdaoe_nxt = sdaoe_r; sdalv_nxt = sdalv_r;
    bit_inc = 1'b0;
    res_nxt = '0;
    if (!q_item.is_tick) begin
      if (ph_r == PH_IDLE && q_item.op != OP_NONE) begin
        op_nxt = q_item.op; dev_nxt = q_item.dev_addr; reg_nxt = q_item.reg_addr;
        dat_nxt = q_item.wr_data; left_nxt = q_item.rd_len;
        step_nxt = 2'd0; pc_nxt = '0; nack_nxt = 1'b0;
        ph_nxt = (q_item.op == OP_RECOVER) ? PH_RC0 : PH_ST0;
      end
    end else begin
      case (ph_r)
        PH_ST0: begin
          scloe_nxt = 1'b1; scllv_nxt = 1'b1; sdaoe_nxt = 1'b1; sdalv_nxt = 1'b1;
          ph_nxt = PH_ST1;
        end
        PH_ST1: begin sdaoe_nxt = 1'b1; sdalv_nxt = 1'b0; ph_nxt = PH_ST2; end
        PH_ST2: begin
          scloe_nxt = 1'b1; scllv_nxt = 1'b0;
          sh_nxt = (step_r == 2'd0) ? dev_r : (dev_r | 8'h01);
          bit_nxt = '0; str_nxt = budget_r; ph_nxt = PH_TX0;
        end
        PH_TX0: begin
          sdaoe_nxt = 1'b1; sdalv_nxt = sh_r[7]; sh_nxt = {sh_r[6:0], 1'b0};
          scloe_nxt = 1'b0; scllv_nxt = 1'b0; ph_nxt = PH_TXW;
        end
        PH_TXW, PH_AKW, PH_RXW: begin
          if (!q_item.scl && str_r != 16'd0) begin
            str_nxt = str_r - 16'd1;
          end else begin
            scloe_nxt = 1'b1; scllv_nxt = 1'b1;
            ph_nxt = (ph_r == PH_TXW) ? PH_TX2 : (ph_r == PH_AKW) ? PH_AK2 : PH_RX2;
          end
        end
        PH_TX2: begin
          scloe_nxt = 1'b1; scllv_nxt = 1'b0; bit_inc = 1'b1;
          ph_nxt = (bit_p1 >= 4'd8) ? PH_AK0 : PH_TX0;
        end
        PH_AK0, PH_RX0: begin
          sdaoe_nxt = 1'b0; sdalv_nxt = 1'b0; scloe_nxt = 1'b0; scllv_nxt = 1'b0;
          ph_nxt = (ph_r == PH_AK0) ? PH_AKW : PH_RXW;
        end
        PH_AK2: begin
          scloe_nxt = 1'b1; scllv_nxt = 1'b0;
          if (q_item.sda) begin
            nack_nxt = 1'b1; ph_nxt = PH_SP0;
          end else if (step_r == 2'd0) begin
            step_nxt = 2'd1; sh_nxt = reg_r; bit_nxt = '0; str_nxt = budget_r;
            ph_nxt = PH_TX0;
          end else if (step_r == 2'd1) begin
            step_nxt = 2'd2;
            if (op_r == OP_WRITE) begin
              sh_nxt = dat_r; bit_nxt = '0; str_nxt = budget_r; ph_nxt = PH_TX0;
            end else begin
              ph_nxt = PH_ST0;
            end
          end else if (op_r == OP_READ && left_r != 8'd0) begin
            sh_nxt = '0; bit_nxt = '0; str_nxt = budget_r; ph_nxt = PH_RX0;
          end else begin
            ph_nxt = PH_SP0;
          end
        end
        PH_RX2: begin
          sh_nxt = {sh_r[6:0], q_item.sda};
          scloe_nxt = 1'b1; scllv_nxt = 1'b0; bit_inc = 1'b1;
          if (bit_p1 >= 4'd8) begin
            res_nxt.rd_valid = 1'b1; res_nxt.rd_byte = {sh_r[6:0], q_item.sda};
            res_nxt.rd_last = (left_r == 8'd1); ph_nxt = PH_MA0;
          end else begin
            ph_nxt = PH_RX0;
          end
        end
        PH_MA0: begin sdaoe_nxt = 1'b1; sdalv_nxt = (left_r == 8'd1); ph_nxt = PH_MA1; end
        PH_MA1: begin scloe_nxt = 1'b1; scllv_nxt = 1'b1; ph_nxt = PH_MA2; end
        PH_MA2: begin
          scloe_nxt = 1'b1; scllv_nxt = 1'b0; left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            ph_nxt = PH_SP0;
          end else begin
            sh_nxt = '0; bit_nxt = '0; str_nxt = budget_r; ph_nxt = PH_RX0;
          end
        end
        PH_SP0: begin sdaoe_nxt = 1'b1; sdalv_nxt = 1'b0; ph_nxt = PH_SP1; end
        PH_SP1: begin scloe_nxt = 1'b1; scllv_nxt = 1'b1; ph_nxt = PH_SP2; end
        PH_SP2: begin
          sdaoe_nxt = 1'b1; sdalv_nxt = 1'b1; res_nxt.done = 1'b1;
          res_nxt.status = nack_r ? ST_NACK : ST_OK; ph_nxt = PH_IDLE;
        end
        PH_RC0: begin scloe_nxt = 1'b1; scllv_nxt = 1'b0; ph_nxt = PH_RC1; end
        PH_RC1: begin sdaoe_nxt = 1'b1; sdalv_nxt = 1'b0; ph_nxt = PH_RC2; end
        PH_RC2: begin scloe_nxt = 1'b1; scllv_nxt = 1'b1; ph_nxt = PH_RC3; end
        PH_RC3: begin
          sdaoe_nxt = 1'b1; sdalv_nxt = 1'b1; pc_nxt = pc_r + 1'b1;
          ph_nxt = (pc_nxt >= PulseW'(RecoveryPulses)) ? PH_RC4 : PH_RC0;
        end
        PH_RC4: begin
          sdaoe_nxt = 1'b0; sdalv_nxt = 1'b0; res_nxt.done = 1'b1;
          res_nxt.status = q_item.sda ? ST_OK : ST_STUCK; ph_nxt = PH_IDLE;
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
    if (bit_inc) bit_nxt = bit_p1;
    res_nxt.scl_oe = scloe_nxt; res_nxt.scl_out = scllv_nxt;
    res_nxt.sda_oe = sdaoe_nxt; res_nxt.sda_out = sdalv_nxt;
    res_nxt.busy = (ph_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; bit_r <= '0; step_r <= '0; sh_r <= '0; left_r <= '0;
      str_r <= '0; op_r <= OP_WRITE; dev_r <= '0; reg_r <= '0; dat_r <= '0;
      pc_r <= '0; nack_r <= 1'b0; scloe_r <= 1'b0; scllv_r <= 1'b0;
      sdaoe_r <= 1'b0; sdalv_r <= 1'b0; rv_r <= 1'b0; budget_r <= StretchReset;
    end else begin
      if (cfg_we) budget_r <= cfg_data;
      if (go) begin
        ph_r <= ph_nxt; bit_r <= bit_nxt; step_r <= step_nxt; sh_r <= sh_nxt;
        left_r <= left_nxt; str_r <= str_nxt; op_r <= op_nxt; dev_r <= dev_nxt;
        reg_r <= reg_nxt; dat_r <= dat_nxt; pc_r <= pc_nxt; nack_r <= nack_nxt;
        scloe_r <= scloe_nxt; scllv_r <= scllv_nxt;
        sdaoe_r <= sdaoe_nxt; sdalv_r <= sdalv_nxt;
      end
      if (go) rv_r <= 1'b1;
      else if (res_take) rv_r <= 1'b0;
    end
    if (go) res_r <= res_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !res_take) |=> ($stable(res_r) && rv_r))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && res_r.done) |-> !res_r.busy)
    else $error("done while still busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && res_r.rd_valid) |-> (res_r.busy && !res_r.done))
    else $error("read byte outside a transfer");
  assert property (@(posedge clk) disable iff (!rst_n) bit_r <= 4'd8)
    else $error("bit count overflow");
endmodule
`default_nettype wire

// ----- tb/sv/i2cm_checker.sv -----
`default_nettype none
module i2cm_checker import i2cm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic        in_kind,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_dev_addr,
  input  wire logic [7:0]  in_reg_addr,
  input  wire logic [7:0]  in_wr_data,
  input  wire logic [7:0]  in_rd_len,
  input  wire logic        in_scl_in,
  input  wire logic        in_sda_in,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic        out_scl_oe,
  input  wire logic        out_scl_out,
  input  wire logic        out_sda_oe,
  input  wire logic        out_sda_out,
  input  wire logic        out_busy_res,
  input  wire logic        out_rd_valid,
  input  wire logic [7:0]  out_rd_byte,
  input  wire logic        out_rd_last,
  input  wire logic        out_done_res,
  input  wire logic [1:0]  out_status,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_stretch_budget,
  output int               errors
);
  logic [15:0] budget;
  phase_t      ph;
  logic [3:0]  bit_cnt;
  logic [2:0]  byte_no;
  logic [7:0]  shreg, bytes_left, dev, regv, wdata;
  logic [15:0] stretch_cnt;
  op_t         cur_op;
  logic [3:0]  pulses;
  logic        scl_oe, scl_lv, sda_oe, sda_lv, nack;
  res_t        pending_res[$];

  task automatic set_scl(input logic on, input logic lvl);
    scl_oe = on;
    scl_lv = on & lvl;
  endtask

  task automatic set_sda(input logic on, input logic lvl);
    sda_oe = on;
    sda_lv = on & lvl;
  endtask

  task automatic start_byte(input logic [7:0] b);
    shreg = b;
    bit_cnt = 0;
    stretch_cnt = budget;
    ph = PH_TX0;
  endtask

  task automatic start_recv();
    shreg = 0;
    bit_cnt = 0;
    stretch_cnt = budget;
    ph = PH_RX0;
  endtask

  task automatic clock_released(input logic scl, output logic go);
    if (!scl && stretch_cnt != 0) begin
      stretch_cnt = stretch_cnt - 1;
      go = 1'b0;
    end else begin
      set_scl(1'b1, 1'b1);
      go = 1'b1;
    end
  endtask

  task automatic bus_step(input item_t it, output res_t r);
    logic go;
    r = '0;
    if (!it.is_tick) begin
      if (ph == PH_IDLE && it.op != OP_NONE) begin
        cur_op = it.op;
        dev = it.dev_addr;
        regv = it.reg_addr;
        wdata = it.wr_data;
        bytes_left = it.rd_len;
        byte_no = 0;
        pulses = 0;
        nack = 1'b0;
        ph = (it.op == OP_RECOVER) ? PH_RC0 : PH_ST0;
      end
    end else begin
      case (ph)
        PH_ST0: begin set_scl(1, 1); set_sda(1, 1); ph = PH_ST1; end
        PH_ST1: begin set_sda(1, 0); ph = PH_ST2; end
        PH_ST2: begin
          set_scl(1, 0);
          start_byte(byte_no == 0 ? dev : (dev | 8'h01));
        end
        PH_TX0: begin
          set_sda(1, shreg[7]);
          shreg = shreg << 1;
          set_scl(0, 0);
          ph = PH_TXW;
        end
        PH_TXW: begin clock_released(it.scl, go); if (go) ph = PH_TX2; end
        PH_TX2: begin
          set_scl(1, 0);
          bit_cnt = bit_cnt + 1;
          ph = (bit_cnt >= 8) ? PH_AK0 : PH_TX0;
        end
        PH_AK0: begin set_sda(0, 0); set_scl(0, 0); ph = PH_AKW; end
        PH_AKW: begin clock_released(it.scl, go); if (go) ph = PH_AK2; end
        PH_AK2: begin
          set_scl(1, 0);
          if (it.sda) begin
            nack = 1'b1;
            ph = PH_SP0;
          end else if (byte_no == 0) begin
            byte_no = 1;
            start_byte(regv);
          end else if (byte_no == 1) begin
            byte_no = 2;
            if (cur_op == OP_WRITE) start_byte(wdata);
            else ph = PH_ST0;
          end else if (cur_op == OP_READ && bytes_left != 0) begin
            start_recv();
          end else begin
            ph = PH_SP0;
          end
        end
        PH_RX0: begin set_sda(0, 0); set_scl(0, 0); ph = PH_RXW; end
        PH_RXW: begin clock_released(it.scl, go); if (go) ph = PH_RX2; end
        PH_RX2: begin
          shreg = {shreg[6:0], it.sda};
          set_scl(1, 0);
          bit_cnt = bit_cnt + 1;
          if (bit_cnt >= 8) begin
            r.rd_valid = 1'b1;
            r.rd_byte = shreg;
            r.rd_last = (bytes_left == 1);
            ph = PH_MA0;
          end else begin
            ph = PH_RX0;
          end
        end
        PH_MA0: begin set_sda(1, bytes_left == 1); ph = PH_MA1; end
        PH_MA1: begin set_scl(1, 1); ph = PH_MA2; end
        PH_MA2: begin
          set_scl(1, 0);
          bytes_left = bytes_left - 1;
          if (bytes_left == 0) ph = PH_SP0;
          else start_recv();
        end
        PH_SP0: begin set_sda(1, 0); ph = PH_SP1; end
        PH_SP1: begin set_scl(1, 1); ph = PH_SP2; end
        PH_SP2: begin
          set_sda(1, 1);
          r.done = 1'b1;
          r.status = nack ? ST_NACK : ST_OK;
          ph = PH_IDLE;
        end
        PH_RC0: begin set_scl(1, 0); ph = PH_RC1; end
        PH_RC1: begin set_sda(1, 0); ph = PH_RC2; end
        PH_RC2: begin set_scl(1, 1); ph = PH_RC3; end
        PH_RC3: begin
          set_sda(1, 1);
          pulses = pulses + 1;
          ph = (pulses >= RecoveryPulses) ? PH_RC4 : PH_RC0;
        end
        PH_RC4: begin
          set_sda(0, 0);
          r.done = 1'b1;
          r.status = it.sda ? ST_OK : ST_STUCK;
          ph = PH_IDLE;
        end
        default: ph = PH_IDLE;
      endcase
    end
    r.scl_oe = scl_oe;
    r.scl_out = scl_lv;
    r.sda_oe = sda_oe;
    r.sda_out = sda_lv;
    r.busy = (ph != PH_IDLE);
  endtask

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    item_t it;
    res_t  want;
    res_t  got;
    if (!rst_n) begin
      budget = StretchReset;
      ph = PH_IDLE;
      bit_cnt = 0; byte_no = 0; shreg = 0; bytes_left = 0; stretch_cnt = 0;
      cur_op = OP_WRITE; dev = 0; regv = 0; wdata = 0; pulses = 0;
      scl_oe = 0; scl_lv = 0; sda_oe = 0; sda_lv = 0; nack = 0;
      pending_res.delete();
    end else begin
      if (cfg_we) budget = cfg_stretch_budget;
      if (pop && !empty) begin
        got = '{out_scl_oe, out_scl_out, out_sda_oe, out_sda_out, out_busy_res,
                out_rd_valid, out_rd_byte, out_rd_last, out_done_res, out_status};
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          errors++;
        end else begin
          want = pending_res.pop_front();
          if (want.scl_oe != got.scl_oe) report("scl_oe", want.scl_oe, got.scl_oe);
          if (want.scl_out != got.scl_out) report("scl_out", want.scl_out, got.scl_out);
          if (want.sda_oe != got.sda_oe) report("sda_oe", want.sda_oe, got.sda_oe);
          if (want.sda_out != got.sda_out) report("sda_out", want.sda_out, got.sda_out);
          if (want.busy != got.busy) report("busy_res", want.busy, got.busy);
          if (want.rd_valid != got.rd_valid) report("rd_valid", want.rd_valid, got.rd_valid);
          if (want.rd_byte != got.rd_byte) report("rd_byte", want.rd_byte, got.rd_byte);
          if (want.rd_last != got.rd_last) report("rd_last", want.rd_last, got.rd_last);
          if (want.done != got.done) report("done_res", want.done, got.done);
          if (want.status != got.status) report("status", want.status, got.status);
        end
      end
      if (push && !full) begin
        it = '{in_kind, op_t'(in_op), in_dev_addr, in_reg_addr, in_wr_data, in_rd_len,
               in_scl_in, in_sda_in};
        bus_step(it, want);
        pending_res.push_back(want);
      end
    end
  end

  final_left: assert property (@(posedge clk) 1'b1);

  function automatic int words_pending();
    return pending_res.size();
  endfunction
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  import i2cm_pkg::*;

  logic        clk, rst_n, push, pop, cfg_we;
  logic        full, empty;
  logic        in_kind, in_scl_in, in_sda_in;
  logic [1:0]  in_op;
  logic [7:0]  in_dev_addr, in_reg_addr, in_wr_data, in_rd_len;
  logic [15:0] cfg_stretch_budget;
  logic        out_scl_oe, out_scl_out, out_sda_oe, out_sda_out, out_busy_res;
  logic        out_rd_valid, out_rd_last, out_done_res;
  logic [7:0]  out_rd_byte;
  logic [1:0]  out_status;
  int          errors;
  int          words_in, words_out, cycles;
  logic        last_busy, hold_req, held, steady_pop;

  i2c_master_register_access DUT (.*);
  i2cm_checker checker_i (.*);

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) words_in++;
    if (rst_n && pop && !empty) begin
      words_out++;
      last_busy <= out_busy_res;
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    int gap;
    pop <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (80) @(posedge clk);
      end
      gap = steady_pop ? 0 : $urandom_range(19);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  logic steady_push;

  task automatic send_word(input logic kind, input logic [1:0] op, input logic [7:0] dv,
                           input logic [7:0] rg, input logic [7:0] wd, input logic [7:0] ln,
                           input logic scl, input logic sda);
    int gap;
    gap = steady_push ? 0 : $urandom_range(19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_kind <= kind; in_op <= op; in_dev_addr <= dv; in_reg_addr <= rg;
    in_wr_data <= wd; in_rd_len <= ln; in_scl_in <= scl; in_sda_in <= sda;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_tick(input int p_sda1, input int p_scl0);
    send_word(1'b1, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              $urandom_range(99) >= p_scl0, $urandom_range(99) < p_sda1);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (words_out != words_in) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // run a command and feed the bus, then tick until the block is idle again
  task automatic run_cmd(input logic [1:0] op, input logic [7:0] dv, input logic [7:0] rg,
                         input logic [7:0] wd, input logic [7:0] ln, input int p_sda1,
                         input int p_scl0, input int nticks);
    send_word(1'b0, op, dv, rg, wd, ln, 1'($urandom), 1'($urandom));
    for (int i = 0; i < nticks; i++) begin
      if ($urandom_range(99) < 4)
        send_word(1'b0, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom), 1'($urandom));
      else
        send_tick(p_sda1, p_scl0);
    end
    drain();
    while (last_busy) begin
      repeat (20) send_tick(p_sda1, 0);
      drain();
    end
  endtask

  task automatic set_budget(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_stretch_budget <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int p1, p0;
    rst_n <= 1'b0; push <= 1'b0; cfg_we <= 1'b0; cfg_stretch_budget <= '0;
    in_kind <= 1'b0; in_op <= OP_WRITE; in_dev_addr <= '0; in_reg_addr <= '0;
    in_wr_data <= '0; in_rd_len <= '0; in_scl_in <= 1'b1; in_sda_in <= 1'b1;
    words_in = 0; words_out = 0; cycles = 0; last_busy = 1'b0;
    hold_req = 1'b0; steady_push = 1'b0; steady_pop = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_tick(50, 0);
    send_word(1'b0, OP_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 1, 1);
    run_cmd(OP_WRITE, 8'h00, 8'hff, 8'h00, 8'h00, 0, 0, 40);
    run_cmd(OP_WRITE, 8'hff, 8'h00, 8'hff, 8'hff, 100, 0, 10);
    run_cmd(OP_READ, 8'ha4, 8'h10, 8'h00, 8'h00, 0, 0, 100);
    run_cmd(OP_READ, 8'ha4, 8'h11, 8'h00, 8'h01, 0, 30, 140);
    run_cmd(OP_RECOVER, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 40);
    run_cmd(OP_RECOVER, 8'h00, 8'h00, 8'h00, 8'h00, 100, 0, 40);

    // random
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_budget(16'd0);
        1: set_budget(16'hffff);
        2: set_budget(16'd3);
        3: set_budget(16'($urandom));
        4: set_budget(16'd1);
        default: set_budget(StretchReset);
      endcase
      steady_push = (s == 2);
      steady_pop = (s == 4);
      if (s == 1) hold_req = 1'b1;
      for (int k = 0; k < 1; k++) begin
        p1 = $urandom_range(3) == 0 ? 50 : $urandom_range(15);
        p0 = (s == 1) ? $urandom_range(3) : $urandom_range(40);
        run_cmd(2'($urandom_range(2)), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom_range(3)), p1, p0, $urandom_range(30, 90));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && checker_i.words_pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_register_access.sv
tb/sv/i2cm_checker.sv
tb/sv/tb_top.sv
